// ===== rtl/msis_pkg.sv =====
// Shared types, codes and constants of the MIPS subset instruction step block.
package msis_pkg;

  localparam int unsigned DMEM_BYTES_DEF = 65536;

  localparam logic [1:0] CMD_LOAD_BYTE = 2'd0;
  localparam logic [1:0] CMD_EXECUTE   = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE = 2'd2;
  localparam logic [1:0] CMD_READ_REG  = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_RNOR    = 6'd63;

  localparam logic [2:0] ALU_ADD = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_NOR = 3'd7;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    DM_NONE,
    DM_READ,
    DM_WR_WORD,
    DM_WR_BYTE
  } dm_op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] instruction;
    logic [15:0] mem_byte_address;
    logic [7:0]  byte_value;
    logic [4:0]  register_index;
  } in_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [31:0] read_value;
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_enable;
    logic [31:0] mem_address;
    logic [31:0] mem_write_value;
  } out_t;

  // Data memory request: byte writes use wdata[31:24]
  typedef struct packed {
    logic        valid;
    dm_op_e      op;
    logic [31:0] addr;
    logic [31:0] wdata;
  } dmem_req_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  // What the execute stage hands to the write-back stage
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        rd_reg;
    logic        rd_mem;
    logic        is_load;
    logic [31:0] reg_value;
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        mem_write_enable;
    logic [31:0] mem_address;
    logic [31:0] mem_write_value;
  } stage_t;

endpackage

// ===== rtl/mips_subset_instruction_step.sv =====
// Top level: MIPS subset step with register read, execute/memory and write-back stages.
// An accepted item is registered into s1_q with its register file read, then into s2_q with its
// data memory read, then into out_q. No new item is taken while one is in s1_q; a load's register
// write must land before the next item reads the register file, which takes it on that same edge.
// Reset clears PC, halt flag, last ALU result and the register file at once; the data
// memory then runs a clearing pass over its DMEM_BYTES/4 rows (16384 by default) with in_ready_o low.
module mips_subset_instruction_step #(
  parameter int unsigned DMEM_BYTES = msis_pkg::DMEM_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msis_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msis_pkg::out_t out_o
);
  import msis_pkg::*;

  logic        s1_v_q, s2_v_q, out_v_q;
  in_t         s1_q;
  stage_t      s2_q, stage;
  out_t        out_q, wb;
  logic        accept, s2_adv, dmem_busy;
  logic [4:0]  rd_addr_a;
  logic [31:0] rs_val, rt_val, ld_word;
  dmem_req_t   dmem_req;
  rf_wr_t      rf_wr;

  assign s2_adv     = s2_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !dmem_busy && !s1_v_q && (!s2_v_q || s2_adv);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_addr_a  = (in_i.command == CMD_READ_REG) ? in_i.register_index
                                                     : in_i.instruction[25:21];

  msis_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (in_i.instruction[20:16]),
    .wr_i        (rf_wr),
    .rd_data_a_o (rs_val),
    .rd_data_b_o (rt_val)
  );

  msis_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_v_q),
    .item_i     (s1_q),
    .rs_val_i   (rs_val),
    .rt_val_i   (rt_val),
    .dmem_req_o (dmem_req),
    .stage_o    (stage)
  );

  msis_dmem #(
    .DMEM_BYTES (DMEM_BYTES)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dmem_req),
    .rd_word_o (ld_word),
    .busy_o    (dmem_busy)
  );

  // Write-back: merge load data and read results
  always_comb begin
    wb.next_pc          = s2_q.next_pc;
    wb.halted           = s2_q.halted;
    wb.read_value       = s2_q.rd_reg ? s2_q.reg_value :
                          (s2_q.rd_mem ? {24'd0, ld_word[31:24]} : '0);
    wb.reg_write_enable = s2_q.reg_write_enable;
    wb.reg_write_index  = s2_q.reg_write_index;
    wb.reg_write_value  = (s2_q.is_load && s2_q.reg_write_enable) ? ld_word
                                                                   : s2_q.reg_write_value;
    wb.mem_write_enable = s2_q.mem_write_enable;
    wb.mem_address      = s2_q.mem_address;
    wb.mem_write_value  = s2_q.mem_write_value;
  end

  assign rf_wr.we   = s2_adv && s2_q.reg_write_enable;
  assign rf_wr.idx  = s2_q.reg_write_index;
  assign rf_wr.data = wb.reg_write_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i;
    end
    if (s1_v_q) begin
      s2_q <= stage;
    end
    if (s2_adv) begin
      out_q <= wb;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/msis_regfile.sv =====
// Register file: 32 x 32 synchronous RAM, two read ports, one write port, cleared by valid bits.
module msis_regfile (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [4:0]       rd_addr_a_i,
  input  logic [4:0]       rd_addr_b_i,
  input  msis_pkg::rf_wr_t wr_i,
  output logic [31:0]      rd_data_a_o,
  output logic [31:0]      rd_data_b_o
);
  import msis_pkg::*;

  logic [31:0] ram_q [32];
  logic [31:0] ram_a_q, ram_b_q, fwd_data_q;
  logic [31:0] vld_q;
  logic        vld_a_q, vld_b_q, fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      ram_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      ram_a_q    <= ram_q[rd_addr_a_i];
      ram_b_q    <= ram_q[rd_addr_b_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // Track written entries and bypass a write landing on the read edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= vld_q[rd_addr_a_i];
        vld_b_q <= vld_q[rd_addr_b_i];
        fwd_a_q <= wr_i.we && (wr_i.idx == rd_addr_a_i);
        fwd_b_q <= wr_i.we && (wr_i.idx == rd_addr_b_i);
      end
    end
  end

  assign rd_data_a_o = fwd_a_q ? fwd_data_q : (vld_a_q ? ram_a_q : '0);
  assign rd_data_b_o = fwd_b_q ? fwd_data_q : (vld_b_q ? ram_b_q : '0);

endmodule

// ===== rtl/msis_dmem.sv =====
// Data memory: four byte banks for unaligned big-endian words, with a clearing pass after reset.
module msis_dmem #(
  parameter int unsigned DMEM_BYTES = msis_pkg::DMEM_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msis_pkg::dmem_req_t req_i,
  output logic [31:0]         rd_word_o,
  output logic                busy_o
);
  import msis_pkg::*;

  localparam int unsigned AW   = $clog2(DMEM_BYTES);
  localparam int unsigned RAW  = AW - 2;
  localparam int unsigned ROWS = DMEM_BYTES / 4;

  logic [RAW-1:0] clr_cnt_q;
  logic           clr_q;
  logic [1:0]     off_q;
  logic [7:0]     bank_rd [4];
  logic           rd_en;

  assign rd_en  = req_i.valid && (req_i.op == DM_READ) && !clr_q;
  assign busy_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      off_q <= req_i.addr[1:0];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]     mem_q [ROWS];
    logic [7:0]     rd_q;
    logic [1:0]     lane;
    logic [AW-1:0]  byte_addr;
    logic [RAW-1:0] row;
    logic [31:0]    shifted;
    logic           wr_en;
    logic [7:0]     wr_byte;

    // Byte of the word that falls into this bank
    assign lane      = 2'(b) - req_i.addr[1:0];
    assign byte_addr = req_i.addr[AW-1:0] + AW'(lane);
    assign shifted   = req_i.wdata >> {~lane, 3'b000};
    assign wr_en     = clr_q || (req_i.valid && ((req_i.op == DM_WR_WORD) ||
                       ((req_i.op == DM_WR_BYTE) && (lane == 2'd0))));
    assign wr_byte   = clr_q ? 8'h00 : shifted[7:0];
    assign row       = clr_q ? clr_cnt_q : byte_addr[AW-1:2];

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem_q[row] <= wr_byte;
      end
      if (rd_en) begin
        rd_q <= mem_q[row];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_comb begin
    rd_word_o = '0;
    for (int i = 0; i < 4; i++) begin
      rd_word_o[31-8*i -: 8] = bank_rd[2'(off_q + 2'(i))];
    end
  end

endmodule

// ===== rtl/msis_exec.sv =====
// Execute stage: decode, ALU, next PC and data memory request; holds PC, halt flag and last ALU result.
module msis_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  msis_pkg::in_t       item_i,
  input  logic [31:0]         rs_val_i,
  input  logic [31:0]         rt_val_i,
  output msis_pkg::dmem_req_t dmem_req_o,
  output msis_pkg::stage_t    stage_o
);
  import msis_pkg::*;

  logic [31:0] pc_q, alu_q;
  logic        halt_q;

  logic        exe, halt_word, run;
  logic [5:0]  op;
  logic [4:0]  rt, rdn, dest;
  logic [31:0] sext, opb, res, pc4, pc_d;
  logic [2:0]  code;
  logic        is_load, is_store, is_imm, is_write, reg_we;

  always_comb begin
    exe       = (item_i.command == CMD_EXECUTE) && !halt_q;
    halt_word = (item_i.instruction == HALT_WORD);
    run       = exe && !halt_word;
    op        = item_i.instruction[31:26];
    rt        = item_i.instruction[20:16];
    rdn       = item_i.instruction[15:11];
    sext      = {{16{item_i.instruction[15]}}, item_i.instruction[15:0]};
    is_load   = (op == OP_LW);
    is_store  = (op == OP_SW);
    is_imm    = (op != OP_SPECIAL) && (op != OP_J) && (op != OP_RNOR);
    is_write  = !is_store && (op != OP_J) && (op != OP_BEQ);

    if (op == OP_SPECIAL) begin
      code = item_i.instruction[2:0];
    end else if (is_load || is_store) begin
      code = ALU_ADD;
    end else begin
      code = op[2:0];
    end

    opb = is_imm ? sext : rt_val_i;
    case (code)
      ALU_ADD: res = rs_val_i + opb;
      ALU_SUB: res = rs_val_i - opb;
      ALU_AND: res = rs_val_i & opb;
      ALU_OR:  res = rs_val_i | opb;
      ALU_NOR: res = ~(rs_val_i | opb);
      default: res = alu_q;
    endcase

    dest   = is_imm ? rt : rdn;
    reg_we = run && is_write && (dest != 5'd0);

    pc4 = pc_q + 32'd4;
    if (!run) begin
      pc_d = pc_q;
    end else if ((op == OP_BEQ) && (rs_val_i == rt_val_i)) begin
      pc_d = pc4 + {sext[29:0], 2'b00};
    end else if (op == OP_J) begin
      pc_d = {pc4[31:28], item_i.instruction[25:0], 2'b00};
    end else begin
      pc_d = pc4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      alu_q  <= '0;
      halt_q <= 1'b0;
    end else if (valid_i && exe) begin
      if (halt_word) begin
        halt_q <= 1'b1;
      end else begin
        pc_q  <= pc_d;
        alu_q <= res;
      end
    end
  end

  always_comb begin
    dmem_req_o.valid = valid_i;
    dmem_req_o.op    = DM_NONE;
    dmem_req_o.addr  = '0;
    dmem_req_o.wdata = '0;
    case (item_i.command)
      CMD_LOAD_BYTE: begin
        dmem_req_o.op    = DM_WR_BYTE;
        dmem_req_o.addr  = {16'd0, item_i.mem_byte_address};
        dmem_req_o.wdata = {item_i.byte_value, 24'd0};
      end
      CMD_READ_BYTE: begin
        dmem_req_o.op   = DM_READ;
        dmem_req_o.addr = {16'd0, item_i.mem_byte_address};
      end
      CMD_EXECUTE: begin
        if (run && is_store) begin
          dmem_req_o.op    = DM_WR_WORD;
          dmem_req_o.addr  = res;
          dmem_req_o.wdata = rt_val_i;
        end else if (run && is_load) begin
          dmem_req_o.op   = DM_READ;
          dmem_req_o.addr = res;
        end
      end
      default: dmem_req_o.op = DM_NONE;
    endcase
  end

  always_comb begin
    stage_o.next_pc          = pc_d;
    stage_o.halted           = halt_q || (exe && halt_word);
    stage_o.rd_reg           = (item_i.command == CMD_READ_REG);
    stage_o.rd_mem           = (item_i.command == CMD_READ_BYTE);
    stage_o.is_load          = run && is_load;
    stage_o.reg_value        = rs_val_i;
    stage_o.reg_write_enable = reg_we;
    stage_o.reg_write_index  = reg_we ? dest : 5'd0;
    stage_o.reg_write_value  = reg_we ? res : '0;
    stage_o.mem_write_enable = run && is_store;
    stage_o.mem_address      = (run && (is_load || is_store)) ? res : '0;
    stage_o.mem_write_value  = (run && is_store) ? rt_val_i : '0;
  end

endmodule

// ===== rtl/msis_checker.sv =====
// Port checker for the MIPS subset step block, bound to the top level.
module msis_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input msis_pkg::out_t out_o
);
  import msis_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result item changed while stalled");

  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted on two consecutive edges");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_o.halted |=> !out_valid_o || out_o.halted)
    else $error("halt flag dropped");

  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.reg_write_enable |-> out_o.reg_write_index != 5'd0)
    else $error("write to register zero reported");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.reg_write_enable && out_o.mem_write_enable))
    else $error("register and memory write in one item");

endmodule

bind mips_subset_instruction_step msis_checker u_msis_checker (.*);
